### rtl/apv_pedestal_peak_hit_finder_core_defines.svh
// ----------------------------------------------------------------------------
// APV peak hit finder assertion macros
// Shared concurrent assertion forms for the peak hit finder core.
// ----------------------------------------------------------------------------
`ifndef APV_PEDESTAL_PEAK_HIT_FINDER_CORE_DEFINES_SVH
`define APV_PEDESTAL_PEAK_HIT_FINDER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define APHF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define APHF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/aphf_pkg.sv
// ----------------------------------------------------------------------------
// APV peak hit finder package
// Sizes, codes and shared types of the peak hit finder core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aphf_pkg;

  localparam int MAX_WINDOWS = 512;
  localparam int MAX_SLICES  = 16;
  localparam int MAX_APV     = 16;

  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 9;
  localparam int SLICE_W  = 4;
  localparam int ADC_W    = 12;
  localparam int APV_W    = 4;
  localparam int PLANE_W  = 4;
  localparam int STRIP_W  = 12;
  localparam int PH_W     = 17;
  localparam int TIME_W   = 12;
  localparam int TPS_W    = 8;
  localparam int NSLC_W   = 5;
  localparam int SUM_W    = 24;

  localparam int SAMP_AW    = SLOT_W + SLICE_W;
  localparam int SAMP_DEPTH = MAX_WINDOWS * MAX_SLICES;
  localparam int SUM_AW     = APV_W + SLICE_W;
  localparam int SUM_DEPTH  = MAX_APV * MAX_SLICES;
  localparam int PED_SHIFT  = 7;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 17;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [PH_W-1:0]   THR_RESET   = PH_W'(400);
  localparam logic [TPS_W-1:0]  TPS_RESET   = TPS_W'(25);
  localparam logic [NSLC_W-1:0] NSLC_RESET  = NSLC_W'(16);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_EVAL  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_TIME      = 2'd1,
    REG_SLICES    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_LOAD_SUM,
    OP_EVAL,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ACC,
    B_INFO,
    B_SCAN,
    B_DONE
  } back_state_t;

  typedef struct packed {
    op_t                 op;
    logic [SLOT_W-1:0]   slot;
    logic [SLICE_W-1:0]  slice;
    logic [ADC_W-1:0]    adc;
    logic [APV_W-1:0]    apv;
    logic [PLANE_W-1:0]  plane;
    logic [STRIP_W-1:0]  strip;
  } cmd_t;

  typedef struct packed {
    logic [PLANE_W-1:0]  plane;
    logic [STRIP_W-1:0]  strip;
    logic [APV_W-1:0]    apv;
  } info_t;

  typedef struct packed {
    logic [PH_W-1:0]    peak_threshold;
    logic [TPS_W-1:0]   time_per_sample;
    logic [NSLC_W-1:0]  active_slices;
  } cfg_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [QCNT_W-1:0]  count;
  } q_stat_t;

  typedef struct packed {
    logic                hit_found;
    logic [PH_W-1:0]     peak_height;
    logic [PLANE_W-1:0]  hit_plane;
    logic [STRIP_W-1:0]  hit_strip;
    logic [TIME_W-1:0]   hit_time;
  } res_t;

endpackage

### rtl/aphf_front.sv
// ----------------------------------------------------------------------------
// APV peak hit finder front end
// Holds the configuration registers and classifies accepted words into
// commands for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aphf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [aphf_pkg::MODE_W-1:0]  in_mode,
  input  logic [aphf_pkg::SLOT_W-1:0]  in_window_slot,
  input  logic [aphf_pkg::SLICE_W-1:0] in_slice_index,
  input  logic [aphf_pkg::ADC_W-1:0]   in_adc_sample,
  input  logic [aphf_pkg::APV_W-1:0]   in_apv_number,
  input  logic [aphf_pkg::PLANE_W-1:0] in_plane_number,
  input  logic [aphf_pkg::STRIP_W-1:0] in_strip_number,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [aphf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aphf_pkg::CFG_DW-1:0]  cfg_data,
  input  aphf_pkg::q_stat_t            q_stat,
  output logic                         push,
  output aphf_pkg::cmd_t               push_cmd,
  output aphf_pkg::cfg_t               cfg
);
  import aphf_pkg::*;

  logic [PH_W-1:0]   thr_r;
  logic [TPS_W-1:0]  tps_r;
  logic [NSLC_W-1:0] nslc_r;
  logic [NSLC_W-1:0] active;
  logic              accept;
  logic              slot_ok;
  logic              slice_ok;
  logic              sum_ok;
  logic              keep;
  op_t               op;

  assign cfg_ready = 1'b1;
  assign busy      = q_stat.full;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      tps_r  <= TPS_RESET;
      nslc_r <= NSLC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_THRESHOLD: thr_r  <= cfg_data[PH_W-1:0];
        REG_TIME:      tps_r  <= cfg_data[TPS_W-1:0];
        REG_SLICES:    nslc_r <= cfg_data[NSLC_W-1:0];
        default: ;
      endcase
    end
  end

  assign active = (int'(nslc_r) > MAX_SLICES) ? NSLC_W'(MAX_SLICES) : nslc_r;

  assign cfg.peak_threshold  = thr_r;
  assign cfg.time_per_sample = tps_r;
  assign cfg.active_slices   = active;

  assign slot_ok  = int'(in_window_slot) < MAX_WINDOWS;
  assign slice_ok = int'(in_slice_index) < MAX_SLICES;
  assign sum_ok   = (int'(in_apv_number) < MAX_APV) &&
                    ({1'b0, in_slice_index} < active);

  always_comb begin
    op   = OP_LOAD;
    keep = 1'b0;
    case (mode_t'(in_mode))
      MODE_LOAD: begin
        op   = sum_ok ? OP_LOAD_SUM : OP_LOAD;
        keep = slot_ok && slice_ok;
      end
      MODE_EVAL: begin
        op   = OP_EVAL;
        keep = slot_ok;
      end
      MODE_CLEAR: begin
        op   = OP_CLEAR;
        keep = 1'b1;
      end
      default: begin
        op   = OP_LOAD;
        keep = 1'b0;
      end
    endcase
  end

  assign push           = accept && keep;
  assign push_cmd.op    = op;
  assign push_cmd.slot  = in_window_slot;
  assign push_cmd.slice = in_slice_index;
  assign push_cmd.adc   = in_adc_sample;
  assign push_cmd.apv   = in_apv_number;
  assign push_cmd.plane = in_plane_number;
  assign push_cmd.strip = in_strip_number;

endmodule

### rtl/aphf_queue.sv
// ----------------------------------------------------------------------------
// APV peak hit finder command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aphf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  aphf_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output aphf_pkg::cmd_t    head,
  output aphf_pkg::q_stat_t q_stat
);
  import aphf_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head         = mem_r[rptr_r];
  assign q_stat.count = cnt_r;
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));

endmodule

### rtl/aphf_back.sv
// ----------------------------------------------------------------------------
// APV peak hit finder back end
// Executes queued commands against the sample, window and pedestal stores
// and scans one window a slice per cycle for its peak.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aphf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  aphf_pkg::cmd_t    head,
  input  aphf_pkg::q_stat_t q_stat,
  input  aphf_pkg::cfg_t    cfg,
  output logic              pop,
  output logic              res_valid,
  output aphf_pkg::res_t    res
);
  import aphf_pkg::*;

  logic [ADC_W-1:0]  samp_mem [SAMP_DEPTH];
  info_t             info_mem [MAX_WINDOWS];
  logic [SUM_W-1:0]  sum_mem  [SUM_DEPTH];
  logic [SUM_DEPTH-1:0] sum_vld_r;

  logic               samp_we;
  logic [SAMP_AW-1:0] samp_waddr;
  logic               samp_re;
  logic [SAMP_AW-1:0] samp_raddr;
  logic [ADC_W-1:0]   samp_q;

  logic               info_we;
  logic [SLOT_W-1:0]  info_waddr;
  logic               info_re;
  info_t              info_q;

  logic               sum_we;
  logic               sum_re;
  logic               sum_clr;
  logic [SUM_AW-1:0]  sum_waddr;
  logic [SUM_AW-1:0]  sum_raddr;
  logic [SUM_W-1:0]   sum_wdata;
  logic [SUM_W-1:0]   sum_q;
  logic               sum_vld_q;

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [NSLC_W-1:0]  idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic [SLICE_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [PH_W-1:0]    peak_r, peak_nxt;
  logic [SLICE_W-1:0] best_r, best_nxt;
  logic               res_valid_r, res_valid_nxt;
  res_t               res_r, res_nxt;

  logic [SUM_W:0]     acc;
  logic [SUM_W-1:0]   sum_eval;
  logic [SUM_W:0]     diff;
  logic [PH_W-1:0]    val;
  logic               apv_ok;

  always_ff @(posedge clk) begin
    if (samp_we) begin
      samp_mem[samp_waddr] <= cmd_nxt.adc;
    end
    if (samp_re) begin
      samp_q <= samp_mem[samp_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_waddr] <= '{plane: cmd_nxt.plane, strip: cmd_nxt.strip,
                                 apv: cmd_nxt.apv};
    end
    if (info_re) begin
      info_q <= info_mem[head.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    if (sum_re) begin
      sum_q     <= sum_mem[sum_raddr];
      sum_vld_q <= sum_vld_r[sum_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= '0;
    end else if (sum_clr) begin
      sum_vld_r <= '0;
    end else if (sum_we) begin
      sum_vld_r[sum_waddr] <= 1'b1;
    end
  end

  assign acc       = {1'b0, (sum_vld_q ? sum_q : '0)} + (SUM_W+1)'(cmd_r.adc);
  assign sum_wdata = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
  assign sum_waddr = {cmd_r.apv, cmd_r.slice};
  assign info_waddr = cmd_nxt.slot;
  assign samp_waddr = {cmd_nxt.slot, cmd_nxt.slice};

  assign apv_ok   = int'(info_q.apv) < MAX_APV;
  assign sum_eval = (sum_vld_q && apv_ok) ? sum_q : '0;
  assign diff     = {1'b0, sum_eval} - ((SUM_W+1)'(samp_q) << PED_SHIFT);
  assign val      = diff[SUM_W-1:PED_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pend_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    peak_r     <= peak_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    peak_nxt      = peak_r;
    best_nxt      = best_r;
    res_nxt       = res_r;
    res_valid_nxt = 1'b0;
    pop           = 1'b0;
    samp_we       = 1'b0;
    samp_re       = 1'b0;
    samp_raddr    = {cmd_r.slot, idx_r[SLICE_W-1:0]};
    info_we       = 1'b0;
    info_re       = 1'b0;
    sum_we        = 1'b0;
    sum_re        = 1'b0;
    sum_clr       = 1'b0;
    sum_raddr     = {info_q.apv, idx_r[SLICE_W-1:0]};
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
          case (head.op)
            OP_LOAD: begin
              samp_we = 1'b1;
              info_we = 1'b1;
            end
            OP_LOAD_SUM: begin
              samp_we   = 1'b1;
              info_we   = 1'b1;
              sum_re    = 1'b1;
              sum_raddr = {head.apv, head.slice};
              state_nxt = B_ACC;
            end
            OP_EVAL: begin
              info_re   = 1'b1;
              state_nxt = B_INFO;
            end
            OP_CLEAR: begin
              sum_clr = 1'b1;
            end
            default: ;
          endcase
        end
      end
      B_ACC: begin
        sum_we    = 1'b1;
        state_nxt = B_IDLE;
      end
      B_INFO: begin
        peak_nxt  = '0;
        best_nxt  = '0;
        idx_nxt   = NSLC_W'(1);
        pend_nxt  = 1'b0;
        state_nxt = (cfg.active_slices > NSLC_W'(1)) ? B_SCAN : B_DONE;
      end
      B_SCAN: begin
        if (pend_r && !diff[SUM_W] && (val > peak_r)) begin
          peak_nxt = val;
          best_nxt = pend_idx_r;
        end
        if (idx_r < cfg.active_slices) begin
          samp_re      = 1'b1;
          sum_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[SLICE_W-1:0];
          idx_nxt      = idx_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        res_nxt.hit_found   = (peak_r >= cfg.peak_threshold);
        res_nxt.peak_height = peak_r;
        res_nxt.hit_plane   = info_q.plane;
        res_nxt.hit_strip   = info_q.strip;
        res_nxt.hit_time    = TIME_W'(best_r) * TIME_W'(cfg.time_per_sample);
        res_valid_nxt       = 1'b1;
        state_nxt           = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

### rtl/apv_pedestal_peak_hit_finder_core.sv
// ----------------------------------------------------------------------------
// APV pedestal-subtracted peak hit finder
// Collects ADC windows, keeps per-APV pedestal sums and reports peak hits.
// ----------------------------------------------------------------------------
// A word is taken on a rising edge with start high and busy low. Mode 0
// loads one sample, mode 1 evaluates a window, mode 2 starts an event and
// clears the pedestal sums; mode 3 is dropped.
// Accepted words wait in a four-entry queue, so busy rises only when the
// queue is full. The back end runs one word at a time: a plain load and a
// clear finish in the idle state, a summed load reads the pedestal sum and
// then writes it back, and an evaluation reads the window information and
// scans active slices from slice 1 up through the sample store's read port.
// An evaluation gives one result on the out_ ports for one cycle with
// out_valid high; the receiver cannot stall and must take it then.
// Configuration writes are taken at once with cfg_ready held high and are
// meant for an idle block. Reset restores the register defaults, empties the
// queue and clears all pedestal sums; the stores keep undefined contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apv_pedestal_peak_hit_finder_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [aphf_pkg::MODE_W-1:0]    in_mode,
  input  logic [aphf_pkg::SLOT_W-1:0]    in_window_slot,
  input  logic [aphf_pkg::SLICE_W-1:0]   in_slice_index,
  input  logic [aphf_pkg::ADC_W-1:0]     in_adc_sample,
  input  logic [aphf_pkg::APV_W-1:0]     in_apv_number,
  input  logic [aphf_pkg::PLANE_W-1:0]   in_plane_number,
  input  logic [aphf_pkg::STRIP_W-1:0]   in_strip_number,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aphf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aphf_pkg::CFG_DW-1:0]    cfg_data,
  output logic                           out_valid,
  output logic                           out_hit_found,
  output logic [aphf_pkg::PH_W-1:0]      out_peak_height,
  output logic [aphf_pkg::PLANE_W-1:0]   out_hit_plane,
  output logic [aphf_pkg::STRIP_W-1:0]   out_hit_strip,
  output logic [aphf_pkg::TIME_W-1:0]    out_hit_time
);
  import aphf_pkg::*;

  `include "apv_pedestal_peak_hit_finder_core_defines.svh"

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head;
  cfg_t    cfg;
  res_t    res;
  logic    push;
  logic    pop;

  aphf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_window_slot  (in_window_slot),
    .in_slice_index  (in_slice_index),
    .in_adc_sample   (in_adc_sample),
    .in_apv_number   (in_apv_number),
    .in_plane_number (in_plane_number),
    .in_strip_number (in_strip_number),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_stat          (q_stat),
    .push            (push),
    .push_cmd        (push_cmd),
    .cfg             (cfg)
  );

  aphf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  aphf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .cfg       (cfg),
    .pop       (pop),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_hit_found   = res.hit_found;
  assign out_peak_height = res.peak_height;
  assign out_hit_plane   = res.hit_plane;
  assign out_hit_strip   = res.hit_strip;
  assign out_hit_time    = res.hit_time;

  `APHF_ASSERT_NEXT(a_result_gap, out_valid, !out_valid, "results on consecutive cycles")
  `APHF_ASSERT_SAME(a_zero_peak_time, out_valid && (out_peak_height == '0), out_hit_time == '0, "time without peak")
  `APHF_ASSERT_SAME(a_queue_bound, 1'b1, q_stat.count <= QCNT_W'(QDEPTH), "queue overfilled")
  `APHF_ASSERT_SAME(a_busy_full, busy, !push, "push while queue full")

endmodule
